@@ hw/rtl/hid_descriptor_usage_scanner_macros.svh @@
// ---------------------------------------------------------------------------
// hid_descriptor_usage_scanner_macros.svh
// Assertion macros shared by the descriptor scanner RTL.
// ---------------------------------------------------------------------------
`ifndef HID_DESCRIPTOR_USAGE_SCANNER_MACROS_SVH
`define HID_DESCRIPTOR_USAGE_SCANNER_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define HDUS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define HDUS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/hdus_pkg.sv @@
// ---------------------------------------------------------------------------
// hdus_pkg
// Types and constants for the HID descriptor usage scanner.
// ---------------------------------------------------------------------------
package hdus_pkg;

	localparam int NUM_CFG   = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PAGE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLLECTION  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DESCRIPTION = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATION    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_ID    = 3'd5;

	typedef logic [CFG_W-1:0] cfg_word_t;

	localparam cfg_word_t CFG_RESET_VALS [NUM_CFG] = '{
		16'h0020, 16'h00E1, 16'h0308, 16'h0544, 16'h0545, 16'h0546
	};

	// parser phases
	localparam logic [1:0] PH_PREFIX   = 2'd0;
	localparam logic [1:0] PH_DATA     = 2'd1;
	localparam logic [1:0] PH_LONG_LEN = 2'd2;
	localparam logic [1:0] PH_LONG_TAG = 2'd3;

	localparam logic [7:0] LONG_PREFIX = 8'hFE;

	// short item types and tags
	localparam logic [1:0] TYPE_MAIN   = 2'd0;
	localparam logic [1:0] TYPE_GLOBAL = 2'd1;
	localparam logic [1:0] TYPE_LOCAL  = 2'd2;
	localparam logic [3:0] TAG_USAGE_PAGE = 4'h0;
	localparam logic [3:0] TAG_USAGE      = 4'h0;
	localparam logic [3:0] TAG_COLLECTION = 4'hA;
	localparam logic [1:0] SIZE_FOUR      = 2'd3;

	localparam logic [31:0] COLL_APPLICATION = 32'h0000_0001;

	// flag bit positions
	localparam int FLAG_SENSOR = 0;
	localparam int FLAG_DESC   = 1;
	localparam int FLAG_ROT    = 2;
	localparam int FLAG_VEL    = 3;
	localparam int FLAG_RESET  = 4;
	localparam int NUM_FLAGS   = 5;

	typedef logic [NUM_FLAGS-1:0] flags_t;

endpackage

@@ hw/rtl/hdus_if.sv @@
// ---------------------------------------------------------------------------
// hdus_if
// Valid/ready channels of the descriptor scanner: byte stream in, flags out.
// ---------------------------------------------------------------------------
interface hdus_desc_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface hdus_result_if;
	logic valid;
	logic ready;
	logic sensor_collection;
	logic has_description;
	logic has_rotation;
	logic has_velocity;
	logic has_reset;
	logic full_match;

	modport source (output valid, sensor_collection, has_description, has_rotation,
		has_velocity, has_reset, full_match, input ready);
	modport sink   (input valid, sensor_collection, has_description, has_rotation,
		has_velocity, has_reset, full_match, output ready);
endinterface

@@ hw/rtl/hid_descriptor_usage_scanner.sv @@
// ---------------------------------------------------------------------------
// hid_descriptor_usage_scanner
// Parses a HID report descriptor byte stream and reports which watched
// usages and which application collection it declares.
// ---------------------------------------------------------------------------
//
//  channel | dir | payload                                   | transfer when
//  --------+-----+-------------------------------------------+------------------
//  desc    | in  | data_byte[7:0], last_byte                 | valid && ready
//  result  | out | sensor_collection, has_description,       | valid && ready
//          |     | has_rotation, has_velocity, has_reset,    |
//          |     | full_match                                |
//  cfg_*   | in  | cfg_index[2:0], cfg_wdata[15:0]           | cfg_we
//
// One descriptor byte per cycle unless a last byte waits in _s1. A byte is
// captured in the input register (_s1) and decoded combinationally against
// the parser state; a last byte then loads the result register as it leaves
// _s1. Reset clears the parser state and loads the register defaults.
// A last byte waits in _s1 only while the result register is full and
// not being drained; other bytes never stall.
// ---------------------------------------------------------------------------
`include "hid_descriptor_usage_scanner_macros.svh"

module hid_descriptor_usage_scanner (
	input  logic                           clk,
	input  logic                           arst_n,
	hdus_desc_if.sink                      desc,
	hdus_result_if.source                  result,
	input  logic                           cfg_we,
	input  logic [hdus_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hdus_pkg::CFG_W-1:0]     cfg_wdata
);
	import hdus_pkg::*;

	// configuration registers
	cfg_word_t cfg_q [NUM_CFG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) begin
				cfg_q[i] <= CFG_RESET_VALS[i];
			end
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_CFG))) begin
			cfg_q[cfg_index] <= cfg_wdata;
		end
	end

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance_s1;
	logic       out_valid_q;

	// a last byte needs room in the result register; others always move on
	assign advance_s1 = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign desc.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (desc.ready) begin
			valid_s1 <= desc.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (desc.ready && desc.valid) begin
			byte_s1 <= desc.data_byte;
			last_s1 <= desc.last_byte;
		end
	end

	// parser state
	logic [1:0]  phase_q;
	logic [1:0]  type_q;
	logic [3:0]  tag_q;
	logic [2:0]  left_q;
	logic [1:0]  idx_q;
	logic [31:0] acc_q;
	logic [15:0] page_q;
	logic [31:0] usage_q;
	logic [7:0]  skip_q;
	flags_t      flags_q;

	logic [1:0]  phase_d;
	logic [1:0]  type_d;
	logic [3:0]  tag_d;
	logic [2:0]  left_d;
	logic [1:0]  idx_d;
	logic [31:0] acc_d;
	logic [15:0] page_d;
	logic [31:0] usage_d;
	logic [7:0]  skip_d;
	flags_t      flags_d;

	// item completion
	logic        ap_en;
	logic [1:0]  ap_type;
	logic [3:0]  ap_tag;
	logic [31:0] ap_value;
	logic        ap_four;
	logic [31:0] acc_new;
	logic [31:0] usage_new;

	assign acc_new = acc_q | ({24'h0, byte_s1} << {idx_q, 3'b000});
	// a 4-byte usage carries its own page; shorter ones take the current page
	assign usage_new = ap_four ? ap_value : {page_q, ap_value[15:0]};

	always_comb begin
		phase_d  = phase_q;
		type_d   = type_q;
		tag_d    = tag_q;
		left_d   = left_q;
		idx_d    = idx_q;
		acc_d    = acc_q;
		skip_d   = skip_q;
		ap_en    = 1'b0;
		ap_type  = type_q;
		ap_tag   = tag_q;
		ap_value = 32'h0;
		ap_four  = 1'b0;

		unique case (phase_q)
			PH_PREFIX: begin
				if (skip_q != 8'h0) begin
					// still inside long item data
					skip_d = skip_q - 8'd1;
				end else if (byte_s1 == LONG_PREFIX) begin
					phase_d = PH_LONG_LEN;
				end else begin
					type_d  = byte_s1[3:2];
					tag_d   = byte_s1[7:4];
					acc_d   = 32'h0;
					idx_d   = 2'd0;
					ap_type = byte_s1[3:2];
					ap_tag  = byte_s1[7:4];
					if (byte_s1[1:0] == 2'd0) begin
						ap_en = 1'b1;
					end else begin
						left_d  = (byte_s1[1:0] == SIZE_FOUR) ? 3'd4 : {1'b0, byte_s1[1:0]};
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				acc_d  = acc_new;
				left_d = left_q - 3'd1;
				idx_d  = idx_q + 2'd1;
				if (left_q == 3'd1) begin
					ap_en    = 1'b1;
					ap_value = acc_new;
					ap_four  = (idx_q == 2'd3);
					phase_d  = PH_PREFIX;
				end
			end
			PH_LONG_LEN: begin
				skip_d  = byte_s1;
				phase_d = PH_LONG_TAG;
			end
			PH_LONG_TAG: begin
				phase_d = PH_PREFIX;
			end
			default: begin
				phase_d = PH_PREFIX;
			end
		endcase
	end

	// item effects on page, usage and flags
	always_comb begin
		page_d  = page_q;
		usage_d = usage_q;
		flags_d = flags_q;
		if (ap_en) begin
			priority if (ap_type == TYPE_GLOBAL && ap_tag == TAG_USAGE_PAGE) begin
				page_d = ap_value[15:0];
			end else if (ap_type == TYPE_LOCAL && ap_tag == TAG_USAGE) begin
				usage_d = usage_new;
				if (usage_new[31:16] == cfg_q[CFG_TARGET_PAGE]) begin
					if (usage_new[15:0] == cfg_q[CFG_DESCRIPTION]) flags_d[FLAG_DESC]  = 1'b1;
					if (usage_new[15:0] == cfg_q[CFG_ROTATION])    flags_d[FLAG_ROT]   = 1'b1;
					if (usage_new[15:0] == cfg_q[CFG_VELOCITY])    flags_d[FLAG_VEL]   = 1'b1;
					if (usage_new[15:0] == cfg_q[CFG_RESET_ID])    flags_d[FLAG_RESET] = 1'b1;
				end
			end else if (ap_type == TYPE_MAIN && ap_tag == TAG_COLLECTION) begin
				if (ap_value == COLL_APPLICATION &&
				    usage_q[31:16] == cfg_q[CFG_TARGET_PAGE] &&
				    usage_q[15:0] == cfg_q[CFG_COLLECTION]) begin
					flags_d[FLAG_SENSOR] = 1'b1;
				end
				usage_d = 32'h0;
			end else begin
				// other items carry nothing we track
				page_d = page_q;
			end
		end
	end

	// state update; a last byte restarts the parser for the next descriptor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX;
			type_q  <= 2'd0;
			tag_q   <= 4'd0;
			left_q  <= 3'd0;
			idx_q   <= 2'd0;
			acc_q   <= 32'h0;
			page_q  <= 16'h0;
			usage_q <= 32'h0;
			skip_q  <= 8'h0;
			flags_q <= '0;
		end else if (advance_s1) begin
			if (last_s1) begin
				phase_q <= PH_PREFIX;
				type_q  <= 2'd0;
				tag_q   <= 4'd0;
				left_q  <= 3'd0;
				idx_q   <= 2'd0;
				acc_q   <= 32'h0;
				page_q  <= 16'h0;
				usage_q <= 32'h0;
				skip_q  <= 8'h0;
				flags_q <= '0;
			end else begin
				phase_q <= phase_d;
				type_q  <= type_d;
				tag_q   <= tag_d;
				left_q  <= left_d;
				idx_q   <= idx_d;
				acc_q   <= acc_d;
				page_q  <= page_d;
				usage_q <= usage_d;
				skip_q  <= skip_d;
				flags_q <= flags_d;
			end
		end
	end

	// result register
	flags_t res_flags_q;
	logic   res_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_s1) begin
			res_flags_q <= flags_d;
			res_full_q  <= &flags_d;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.sensor_collection = res_flags_q[FLAG_SENSOR];
	assign result.has_description   = res_flags_q[FLAG_DESC];
	assign result.has_rotation      = res_flags_q[FLAG_ROT];
	assign result.has_velocity      = res_flags_q[FLAG_VEL];
	assign result.has_reset         = res_flags_q[FLAG_RESET];
	assign result.full_match        = res_full_q;

	// checks
	`HDUS_ASSERT_NXT(a_restart, advance_s1 && last_s1, phase_q == PH_PREFIX && flags_q == '0 && skip_q == 8'h0, "parser not restarted after last byte")
	`HDUS_ASSERT_IMP(a_result_src, out_valid_q && !$past(out_valid_q), $past(advance_s1 && last_s1), "result without a last byte")
	`HDUS_ASSERT_IMP(a_data_left, phase_q == PH_DATA, left_q != 3'd0, "data phase with no bytes left")
	`HDUS_ASSERT_IMP(a_skip_phase, skip_q != 8'h0, phase_q == PH_PREFIX || phase_q == PH_LONG_TAG, "long skip count outside prefix phase")
	`HDUS_ASSERT_IMP(a_full_match, out_valid_q, res_full_q == (&res_flags_q), "full_match disagrees with flags")

endmodule

@@ dv/hdus_scan_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hdus_scan_checker
// Watches the byte and result channels of the descriptor scanner, predicts
// the flag report of each descriptor and compares it with every result.
// ---------------------------------------------------------------------------
module hdus_scan_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	hdus_desc_if                           desc,
	hdus_result_if                         result,
	input  logic                           cfg_we,
	input  logic [hdus_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hdus_pkg::CFG_W-1:0]     cfg_wdata,
	output int                             mismatch_count,
	output int                             reports_pending
);
	import hdus_pkg::*;

	typedef struct packed {
		logic sensor_collection;
		logic has_description;
		logic has_rotation;
		logic has_velocity;
		logic has_reset;
		logic full_match;
	} flag_report_t;

	// parser copy
	logic [1:0]  scan_phase;
	logic [1:0]  item_kind;
	logic [3:0]  item_code;
	logic [2:0]  bytes_left;
	logic [1:0]  byte_pos;
	logic [31:0] item_value;
	logic [15:0] usage_page;
	logic [31:0] usage_now;
	logic [7:0]  long_skip;
	flags_t      flags_seen;
	cfg_word_t   regs [NUM_CFG];

	flag_report_t report_q [$];
	int           fails = 0;

	task clear_scan();
		scan_phase = PH_PREFIX;
		item_kind  = '0;
		item_code  = '0;
		bytes_left = '0;
		byte_pos   = '0;
		item_value = '0;
		usage_page = '0;
		usage_now  = '0;
		long_skip  = '0;
		flags_seen = '0;
	endtask

	task apply_item(input logic [1:0] ty, input logic [3:0] tg, input logic [31:0] val,
			input logic four);
		if (ty == TYPE_GLOBAL && tg == TAG_USAGE_PAGE) begin
			usage_page = val[15:0];
		end else if (ty == TYPE_LOCAL && tg == TAG_USAGE) begin
			// short usage borrows the current page for its upper half
			usage_now = four ? val : ({usage_page, 16'h0000} | val);
			if (usage_now[31:16] == regs[CFG_TARGET_PAGE]) begin
				if (usage_now[15:0] == regs[CFG_DESCRIPTION]) flags_seen[FLAG_DESC] = 1'b1;
				if (usage_now[15:0] == regs[CFG_ROTATION]) flags_seen[FLAG_ROT] = 1'b1;
				if (usage_now[15:0] == regs[CFG_VELOCITY]) flags_seen[FLAG_VEL] = 1'b1;
				if (usage_now[15:0] == regs[CFG_RESET_ID]) flags_seen[FLAG_RESET] = 1'b1;
			end
		end else if (ty == TYPE_MAIN && tg == TAG_COLLECTION) begin
			if (val == COLL_APPLICATION &&
					usage_now == {regs[CFG_TARGET_PAGE], regs[CFG_COLLECTION]})
				flags_seen[FLAG_SENSOR] = 1'b1;
			usage_now = '0;
		end
	endtask

	task scan_byte(input logic [7:0] b, input logic last);
		logic [2:0]   len;
		flag_report_t rpt;
		case (scan_phase)
			PH_PREFIX: begin
				if (long_skip != 0) begin
					long_skip = long_skip - 8'd1;
				end else if (b == LONG_PREFIX) begin
					scan_phase = PH_LONG_LEN;
				end else begin
					len        = (b[1:0] == SIZE_FOUR) ? 3'd4 : {1'b0, b[1:0]};
					item_kind  = b[3:2];
					item_code  = b[7:4];
					item_value = '0;
					byte_pos   = '0;
					if (len == 0) begin
						apply_item(item_kind, item_code, 32'h0, 1'b0);
					end else begin
						bytes_left = len;
						scan_phase = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				item_value = item_value | ({24'h0, b} << {byte_pos, 3'b000});
				bytes_left = bytes_left - 3'd1;
				if (bytes_left == 0) begin
					apply_item(item_kind, item_code, item_value, byte_pos == 2'd3);
					scan_phase = PH_PREFIX;
				end
				byte_pos = byte_pos + 2'd1;
			end
			PH_LONG_LEN: begin
				long_skip  = b;
				scan_phase = PH_LONG_TAG;
			end
			default: begin
				scan_phase = PH_PREFIX;
			end
		endcase
		if (last) begin
			rpt.sensor_collection = flags_seen[FLAG_SENSOR];
			rpt.has_description   = flags_seen[FLAG_DESC];
			rpt.has_rotation      = flags_seen[FLAG_ROT];
			rpt.has_velocity      = flags_seen[FLAG_VEL];
			rpt.has_reset         = flags_seen[FLAG_RESET];
			rpt.full_match        = &flags_seen;
			report_q.insert(report_q.size(), rpt);
			clear_scan();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		flag_report_t got;
		flag_report_t want;
		if (!arst_n) begin
			clear_scan();
			foreach (regs[i]) regs[i] = CFG_RESET_VALS[i];
			report_q.delete();
		end else begin
			if (cfg_we && cfg_index < NUM_CFG) regs[cfg_index] = cfg_wdata;
			if (result.valid && result.ready) begin
				got.sensor_collection = result.sensor_collection;
				got.has_description   = result.has_description;
				got.has_rotation      = result.has_rotation;
				got.has_velocity      = result.has_velocity;
				got.has_reset         = result.has_reset;
				got.full_match        = result.full_match;
				if (report_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: result %b with no descriptor pending", $time, got);
				end else begin
					want = report_q.pop_front();
					if (got.sensor_collection !== want.sensor_collection ||
							got.has_description !== want.has_description ||
							got.has_rotation !== want.has_rotation ||
							got.has_velocity !== want.has_velocity ||
							got.has_reset !== want.has_reset ||
							got.full_match !== want.full_match) begin
						fails++;
						if (fails <= 10)
							$display("%0t: flags (sensor,desc,rot,vel,reset,full) exp %b got %b",
								$time, want, got);
					end
				end
			end
			if (desc.valid && desc.ready) scan_byte(desc.data_byte, desc.last_byte);
		end
		mismatch_count  <= fails;
		reports_pending <= report_q.size();
	end

endmodule

@@ dv/hid_descriptor_usage_scanner_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hid_descriptor_usage_scanner_tb
// Feeds HID report descriptors into the usage scanner: a few hand-built
// ones, then random descriptors under several register settings, with
// random idle on both channels. A checker beside the block predicts and
// compares each flag report; this module only drives and judges.
// ---------------------------------------------------------------------------
module hid_descriptor_usage_scanner_tb;
	import hdus_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_BYTES  = 110;  // random bytes per register setting
	localparam int NUM_PHASES   = 7;
	localparam int HOLD_PHASE   = 2;    // phase in which the result side stalls long
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 6;    // settle time after the last report, before register writes

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	int mismatch_count;
	int reports_pending;
	int cycle_count = 0;
	int phase_no    = 0;
	int phase_bytes = 0;
	bit hold_done   = 1'b0;

	// register values as last written, so the generator can aim at them
	cfg_word_t  cfg_now [NUM_CFG];
	logic [7:0] descr_bytes [$];
	int         item_start;  // offset of the newest item, for truncation

	hdus_desc_if   desc_ch ();
	hdus_result_if result_ch ();

	hid_descriptor_usage_scanner u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.desc     (desc_ch),
		.result   (result_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	hdus_scan_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.desc           (desc_ch),
		.result         (result_ch),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.mismatch_count (mismatch_count),
		.reports_pending(reports_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// smallest short-item size code that holds v
	function automatic logic [1:0] min_size(logic [31:0] v);
		if (v == 0) return 2'd0;
		if (v < 256) return 2'd1;
		if (v < 65536) return 2'd2;
		return SIZE_FOUR;
	endfunction

	function automatic cfg_word_t phase_value(int p);
		case (p)
			3:       return '0;
			4:       return '1;
			5:       return cfg_word_t'($urandom_range(0, 255));  // one-byte usage forms
			default: return cfg_word_t'($urandom);
		endcase
	endfunction

	// append one byte to the descriptor under construction
	task queue_byte(input logic [7:0] b);
		descr_bytes.insert(descr_bytes.size(), b);
	endtask

	// short item: prefix then data little-endian
	task push_short(input logic [1:0] ty, input logic [3:0] tg, input logic [1:0] sc,
			input logic [31:0] val);
		int n;
		n = (sc == SIZE_FOUR) ? 4 : sc;
		item_start = descr_bytes.size();
		queue_byte({tg, ty, sc});
		for (int i = 0; i < n; i++) queue_byte(val[8*i +: 8]);
	endtask

	task add_page(input logic [15:0] pg);
		logic [15:0] junk;
		junk = 16'($urandom);
		case ($urandom_range(0, 2))
			0:       push_short(TYPE_GLOBAL, TAG_USAGE_PAGE, min_size({16'h0, pg}), {16'h0, pg});
			1:       push_short(TYPE_GLOBAL, TAG_USAGE_PAGE, 2'd2, {16'h0, pg});
			default: push_short(TYPE_GLOBAL, TAG_USAGE_PAGE, SIZE_FOUR, {junk, pg});
		endcase
	endtask

	// short forms rely on the page register, the 4-byte form carries pg itself
	task add_usage(input logic [15:0] pg, input logic [15:0] id);
		case ($urandom_range(0, 2))
			0:       push_short(TYPE_LOCAL, TAG_USAGE, min_size({16'h0, id}), {16'h0, id});
			1:       push_short(TYPE_LOCAL, TAG_USAGE, 2'd2, {16'h0, id});
			default: push_short(TYPE_LOCAL, TAG_USAGE, SIZE_FOUR, {pg, id});
		endcase
	endtask

	// long item; its data is biased toward the long prefix value
	task add_long();
		int         len;
		logic [7:0] b;
		item_start = descr_bytes.size();
		len = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 255) : $urandom_range(0, 5);
		b = 8'($urandom);
		queue_byte(LONG_PREFIX);
		queue_byte(len[7:0]);
		queue_byte(b);
		repeat (len) begin
			b = 8'($urandom);
			if ($urandom_range(0, 3) == 0) b = LONG_PREFIX;
			queue_byte(b);
		end
	endtask

	task add_random_item();
		int          r;
		logic [31:0] rnd;
		logic [15:0] pg;
		logic [15:0] id;
		logic [7:0]  pfx;
		r   = $urandom_range(0, 99);
		rnd = $urandom;
		pg  = ($urandom_range(0, 3) != 0) ? cfg_now[CFG_TARGET_PAGE] : rnd[15:0];
		id  = ($urandom_range(0, 9) < 7) ? cfg_now[$urandom_range(1, NUM_CFG - 1)] : rnd[31:16];
		if (r < 15) begin
			add_page(pg);
		end else if (r < 50) begin
			add_usage(pg, id);
		end else if (r < 62) begin
			push_short(TYPE_MAIN, TAG_COLLECTION, 2'($urandom_range(0, 3)),
				($urandom_range(0, 3) != 0) ? COLL_APPLICATION : rnd);
		end else if (r < 72) begin
			add_long();
		end else begin
			do pfx = 8'($urandom); while (pfx == LONG_PREFIX);
			push_short(pfx[3:2], pfx[7:4], pfx[1:0], rnd);
		end
	endtask

	// One descriptor into descr_bytes: raw noise, a full sensor layout with
	// extras mixed in, or a random item list; the last item is cut short now
	// and then so the descriptor ends inside it.
	task build_descriptor();
		int         kind;
		int         n;
		int         rot;
		logic [7:0] b;
		descr_bytes.delete();
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			n = $urandom_range(1, 12);
			repeat (n) begin
				b = 8'($urandom);
				if ($urandom_range(0, 5) == 0) b = LONG_PREFIX;
				queue_byte(b);
			end
		end else begin
			if (kind < 40) begin
				rot = $urandom_range(0, 3);
				add_page(cfg_now[CFG_TARGET_PAGE]);
				add_usage(cfg_now[CFG_TARGET_PAGE], cfg_now[CFG_COLLECTION]);
				push_short(TYPE_MAIN, TAG_COLLECTION, 2'd1, COLL_APPLICATION);
				for (int k = 0; k < 4; k++) begin
					if ($urandom_range(0, 3) == 0) add_random_item();
					if ($urandom_range(0, 9) != 0)
						add_usage(cfg_now[CFG_TARGET_PAGE],
							cfg_now[CFG_DESCRIPTION + ((k + rot) % 4)]);
				end
			end else begin
				n = $urandom_range(1, 10);
				repeat (n) add_random_item();
			end
			if ($urandom_range(0, 5) == 0 && descr_bytes.size() - item_start >= 2) begin
				n = $urandom_range(item_start + 1, descr_bytes.size() - 1);
				while (descr_bytes.size() > n) void'(descr_bytes.pop_back());
			end
		end
	endtask

	// Offers descr_bytes one transfer at a time, last byte marked. Valid is
	// left high after the final byte so the next descriptor can follow
	// without a bubble; settle() drops it.
	task send_descriptor();
		int gap;
		bit quiet;
		quiet = ($urandom_range(0, 3) == 0);
		foreach (descr_bytes[i]) begin
			gap = quiet ? 0 : pick_gap();
			if (gap > 0) begin
				@(negedge clk) desc_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			desc_ch.valid     <= 1'b1;
			desc_ch.data_byte <= descr_bytes[i];
			desc_ch.last_byte <= (i == descr_bytes.size() - 1);
			do @(posedge clk); while (!desc_ch.ready);
			phase_bytes++;
		end
	endtask

	// Stop offering, wait for every pending report, then let the pipeline
	// empty of trailing non-last bytes before anything touches the registers.
	task settle();
		@(negedge clk) desc_ch.valid <= 1'b0;
		while (reports_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task write_reg(input int idx, input cfg_word_t val);
		@(negedge clk);
		cfg_we      <= 1'b1;
		cfg_index   <= idx[CFG_IDX_W-1:0];
		cfg_wdata   <= val;
		cfg_now[idx] = val;
	endtask

	// Result side: random ready runs and gaps. In HOLD_PHASE ready goes low
	// for a long stretch while bytes keep coming, so the result register
	// fills and the next last byte backs up the input.
	initial begin : result_drain
		int run;
		int gap;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (phase_no == HOLD_PHASE && !hold_done) begin
				@(negedge clk) result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			run = $urandom_range(1, 30);
			@(negedge clk) result_ch.ready <= 1'b1;
			repeat (run - 1) @(negedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				@(negedge clk) result_ch.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	end

	initial begin : stimulus
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_wdata         = '0;
		desc_ch.valid     = 1'b0;
		desc_ch.data_byte = '0;
		desc_ch.last_byte = 1'b0;
		foreach (cfg_now[i]) cfg_now[i] = CFG_RESET_VALS[i];
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed, default registers. First a complete sensor descriptor:
		// page, application collection, then all four watched usages.
		descr_bytes.delete();
		push_short(TYPE_GLOBAL, TAG_USAGE_PAGE, 2'd1, {16'h0, cfg_now[CFG_TARGET_PAGE]});
		push_short(TYPE_LOCAL, TAG_USAGE, 2'd1, {16'h0, cfg_now[CFG_COLLECTION]});
		push_short(TYPE_MAIN, TAG_COLLECTION, 2'd1, COLL_APPLICATION);
		for (int k = CFG_DESCRIPTION; k <= CFG_RESET_ID; k++)
			push_short(TYPE_LOCAL, TAG_USAGE, 2'd2, {16'h0, cfg_now[k]});
		send_descriptor();

		// Long item whose tag and data look like long prefixes, a 4-byte usage
		// carrying its own page, then an all-ones prefix as the last byte
		// (4-byte item left unfinished, must be dropped).
		descr_bytes.delete();
		queue_byte(LONG_PREFIX);
		queue_byte(8'h01);
		queue_byte(LONG_PREFIX);
		queue_byte(LONG_PREFIX);
		push_short(TYPE_LOCAL, TAG_USAGE, SIZE_FOUR,
			{cfg_now[CFG_TARGET_PAGE], cfg_now[CFG_DESCRIPTION]});
		queue_byte(8'hFF);
		send_descriptor();

		// Random phases, each under its own register setting: defaults first
		// and last, all-zero, all-ones and random values in between.
		for (int p = 1; p <= NUM_PHASES; p++) begin
			settle();
			phase_no = p;
			for (int idx = 0; idx < NUM_CFG; idx++)
				write_reg(idx, (p == 1 || p == NUM_PHASES) ? CFG_RESET_VALS[idx] : phase_value(p));
			@(negedge clk) cfg_we <= 1'b0;
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				build_descriptor();
				send_descriptor();
			end
		end
		settle();

		if (mismatch_count == 0 && reports_pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/hdus_pkg.sv
hw/rtl/hdus_if.sv
hw/rtl/hid_descriptor_usage_scanner.sv
dv/hdus_scan_checker.sv
dv/hid_descriptor_usage_scanner_tb.sv
